@@ rtl/core/grid_ray_cast_column_defines.svh @@
`ifndef GRID_RAY_CAST_COLUMN_DEFINES_SVH
`define GRID_RAY_CAST_COLUMN_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define GRC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("grc assertion failed");

// Next-cycle implication, clocked on aclk, off during reset.
`define GRC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("grc assertion failed");

`endif

@@ rtl/core/grc_pkg.sv @@
package grc_pkg;

    localparam int MAP_DIM_DEF   = 64;
    localparam int TEX_SIZE_DEF  = 64;
    localparam int MAX_STEPS_DEF = 128;

    localparam int DIV_NW = 40;
    localparam int DIV_VW = 32;

    typedef enum logic {
        OPC_WRITE = 1'b0,
        OPC_CAST  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        REG_PLAYER_X,
        REG_PLAYER_Y,
        REG_DIR_X,
        REG_DIR_Y,
        REG_PLANE_X,
        REG_PLANE_Y,
        REG_SCREEN_W,
        REG_SCREEN_H
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CAM_GO,
        ST_CAM_WAIT,
        ST_RAY_MUL,
        ST_RAY_ADD,
        ST_DX_GO,
        ST_DX_WAIT,
        ST_DY_GO,
        ST_DY_WAIT,
        ST_SIDE,
        ST_STEP,
        ST_CHECK,
        ST_PERP_GO,
        ST_PERP_WAIT,
        ST_LH_GO,
        ST_LH_WAIT,
        ST_DRAW,
        ST_TS_GO,
        ST_TS_WAIT,
        ST_FINAL,
        ST_OUT,
        ST_MISS
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_CAM,
        OP_RAY_MUL,
        OP_RAY_ADD,
        OP_DX,
        OP_DY,
        OP_SIDE,
        OP_STEP,
        OP_PERP,
        OP_LH,
        OP_DRAW,
        OP_TSTEP,
        OP_FINAL,
        OP_OUT_HIT,
        OP_OUT_MISS
    } dp_op_t;

    typedef enum logic [2:0] {
        DIV_CAM,
        DIV_DX,
        DIV_DY,
        DIV_PERP,
        DIV_LH,
        DIV_TSTEP
    } div_sel_t;

    typedef struct packed {
        dp_op_t   op;
        logic     div_start;
        div_sel_t div_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_busy;
        logic div_busy;
        logic div_done;
        logic player_in;
        logic off_map;
        logic wall;
        logic step_limit;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/core/grc_div.sv @@
module grc_div
    import grc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_VW-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [DIV_NW-1:0] quotient
);

    localparam int CW = $clog2(DIV_NW);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DIV_VW-1:0] rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_VW-1:0] den_reg;
    logic [DIV_VW:0]   rem_shift;
    logic [DIV_VW:0]   rem_diff;
    logic              fits;

    // restoring, one quotient bit per cycle
    assign rem_shift = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_diff  = rem_shift - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DIV_NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_diff[DIV_VW-1:0] : rem_shift[DIV_VW-1:0];
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/grc_ctrl.sv @@
`include "grid_ray_cast_column_defines.svh"

module grc_ctrl
    import grc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_opcode,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd.op        = OP_NONE;
        cmd.div_start = 1'b0;
        cmd.div_sel   = DIV_CAM;
        s_ready       = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                if (!status.clear_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_ACCEPT;
                    if (s_opcode == OPC_CAST) begin
                        state_next = ST_CAM_GO;
                    end
                end
            end
            ST_CAM_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_CAM;
                state_next    = ST_CAM_WAIT;
            end
            ST_CAM_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = OP_CAM;
                    state_next = ST_RAY_MUL;
                end
            end
            ST_RAY_MUL: begin
                cmd.op     = OP_RAY_MUL;
                state_next = ST_RAY_ADD;
            end
            ST_RAY_ADD: begin
                cmd.op     = OP_RAY_ADD;
                state_next = status.player_in ? ST_DX_GO : ST_MISS;
            end
            ST_DX_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DX;
                state_next    = ST_DX_WAIT;
            end
            ST_DX_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = OP_DX;
                    state_next = ST_DY_GO;
                end
            end
            ST_DY_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DY;
                state_next    = ST_DY_WAIT;
            end
            ST_DY_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = OP_DY;
                    state_next = ST_SIDE;
                end
            end
            ST_SIDE: begin
                cmd.op     = OP_SIDE;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                cmd.op     = OP_STEP;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.off_map) begin
                    state_next = ST_MISS;
                end else if (status.wall) begin
                    state_next = ST_PERP_GO;
                end else if (status.step_limit) begin
                    state_next = ST_MISS;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_PERP_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_PERP;
                state_next    = ST_PERP_WAIT;
            end
            ST_PERP_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = OP_PERP;
                    state_next = ST_LH_GO;
                end
            end
            ST_LH_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_LH;
                state_next    = ST_LH_WAIT;
            end
            ST_LH_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = OP_LH;
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: begin
                cmd.op     = OP_DRAW;
                state_next = ST_TS_GO;
            end
            ST_TS_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_TSTEP;
                state_next    = ST_TS_WAIT;
            end
            ST_TS_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = OP_TSTEP;
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                cmd.op     = OP_FINAL;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.op     = OP_OUT_HIT;
                    state_next = ST_IDLE;
                end
            end
            ST_MISS: begin
                if (status.out_free) begin
                    cmd.op     = OP_OUT_MISS;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `GRC_ASSERT_IMP(a_div_idle, cmd.div_start, !status.div_busy)
    `GRC_ASSERT_IMP(a_out_free, cmd.op == OP_OUT_HIT || cmd.op == OP_OUT_MISS, status.out_free)

endmodule

@@ rtl/core/grc_datapath.sv @@
`include "grid_ray_cast_column_defines.svh"

module grc_datapath
    import grc_pkg::*;
#(
    parameter int MAP_DIM   = MAP_DIM_DEF,
    parameter int TEX_SIZE  = TEX_SIZE_DEF,
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic        [15:0] player_x,
    input  logic        [15:0] player_y,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] plane_x,
    input  logic signed [15:0] plane_y,
    input  logic        [11:0] screen_width,
    input  logic        [11:0] screen_height,
    input  logic               s_opcode,
    input  logic        [5:0]  s_cell_x,
    input  logic        [5:0]  s_cell_y,
    input  logic               s_cell_wall,
    input  logic        [10:0] s_column,
    output logic               m_valid,
    input  logic               m_ready,
    output logic        [10:0] m_column_out,
    output logic               m_hit,
    output logic        [1:0]  m_wall_face,
    output logic        [5:0]  m_hit_cell_x,
    output logic        [5:0]  m_hit_cell_y,
    output logic        [17:0] m_perp_distance,
    output logic        [15:0] m_wall_height,
    output logic        [10:0] m_first_row,
    output logic        [10:0] m_last_row,
    output logic        [5:0]  m_texture_column,
    output logic        [21:0] m_tex_stride,
    output logic        [31:0] m_texture_start
);

    localparam int DEPTH = MAP_DIM * MAP_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = $clog2(MAP_DIM) + 2;
    localparam int SCW   = $clog2(MAX_STEPS + 1);
    localparam logic [MW-1:0] ONE_M = MW'(1);

    // map store
    logic           map_mem [DEPTH];
    logic           rd_data_reg;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  mem_waddr;
    logic           mem_we;
    logic           mem_wdata;
    logic           clear_busy_reg;
    logic [AW-1:0]  clr_addr_reg;
    logic           wr_in_map;

    // ray state
    logic        [10:0]   col_reg;
    logic signed [27:0]   cam_reg;
    logic signed [43:0]   prodx_reg;
    logic signed [43:0]   prody_reg;
    logic signed [43:0]   prodx_sh;
    logic signed [43:0]   prody_sh;
    logic signed [31:0]   rx_reg;
    logic signed [31:0]   ry_reg;
    logic        [31:0]   rx_abs;
    logic        [31:0]   ry_abs;
    logic        [31:0]   dx_reg;
    logic        [31:0]   dy_reg;
    logic        [47:0]   sdx_reg;
    logic        [47:0]   sdy_reg;
    logic        [10:0]   fx;
    logic        [10:0]   fy;
    logic        [42:0]   sdx_prod;
    logic        [42:0]   sdy_prod;
    logic signed [MW-1:0] mx_reg;
    logic signed [MW-1:0] my_reg;
    logic signed [MW-1:0] mx_next;
    logic signed [MW-1:0] my_next;
    logic        [31:0]   mx_u;
    logic        [31:0]   my_u;
    logic                 take_x;
    logic                 side_reg;
    logic        [SCW-1:0] step_cnt_reg;

    // hit math
    logic signed [20:0] num;
    logic        [19:0] num_abs;
    logic        [17:0] perp_reg;
    logic        [15:0] lh_reg;
    logic signed [16:0] ds_reg;
    logic        [10:0] de_reg;
    logic        [15:0] de_sum;
    logic        [15:0] de_val;
    logic        [10:0] h2;
    logic        [14:0] lh2;
    logic        [15:0] factor_reg;
    logic signed [50:0] wprod_reg;
    logic        [21:0] tstep_reg;
    logic        [37:0] tprod;
    logic        [9:0]  wlow;
    logic        [18:0] tmul;

    // divider
    logic              div_busy;
    logic              div_done;
    logic [DIV_NW-1:0] quo;
    logic [DIV_NW-1:0] dvd;
    logic [DIV_VW-1:0] dvs;

    logic m_valid_reg;
    logic out_free;
    logic load_out;

    logic [10:0] column_out_reg;
    logic        hit_reg;
    logic [1:0]  face_reg;
    logic [5:0]  hcx_reg;
    logic [5:0]  hcy_reg;
    logic [17:0] perp_out_reg;
    logic [15:0] lh_out_reg;
    logic [10:0] ds_out_reg;
    logic [10:0] de_out_reg;
    logic [5:0]  tcol_reg;
    logic [5:0]  tcol_out_reg;
    logic [21:0] tstep_out_reg;
    logic [31:0] tstart_reg;
    logic [31:0] tstart_out_reg;

    grc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quo)
    );

    // DDA step candidates
    assign take_x  = sdx_reg < sdy_reg;
    assign mx_next = take_x ? mx_reg + (rx_reg[31] ? {MW{1'b1}} : ONE_M) : mx_reg;
    assign my_next = take_x ? my_reg : my_reg + (ry_reg[31] ? {MW{1'b1}} : ONE_M);
    assign mx_u    = 32'($unsigned(mx_next));
    assign my_u    = 32'($unsigned(my_next));
    assign rd_addr = AW'(my_u * 32'(MAP_DIM) + mx_u);

    assign wr_in_map = (32'(s_cell_x) < 32'(MAP_DIM)) && (32'(s_cell_y) < 32'(MAP_DIM));
    assign wr_addr   = AW'(32'(s_cell_y) * 32'(MAP_DIM) + 32'(s_cell_x));
    assign mem_we    = clear_busy_reg ||
                       (cmd.op == OP_ACCEPT && s_opcode == OPC_WRITE && wr_in_map);
    assign mem_waddr = clear_busy_reg ? clr_addr_reg : wr_addr;
    assign mem_wdata = clear_busy_reg ? 1'b0 : s_cell_wall;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= map_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clear_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    // divider operands
    assign rx_abs  = rx_reg[31] ? 32'(-rx_reg) : 32'(rx_reg);
    assign ry_abs  = ry_reg[31] ? 32'(-ry_reg) : 32'(ry_reg);
    assign num     = side_reg ?
        ((21'(my_reg) <<< 10) - $signed(21'(player_y)) + (ry_reg[31] ? 21'sd1024 : 21'sd0)) :
        ((21'(mx_reg) <<< 10) - $signed(21'(player_x)) + (rx_reg[31] ? 21'sd1024 : 21'sd0));
    assign num_abs = num[20] ? 20'(-num) : 20'(num);

    always_comb begin
        case (cmd.div_sel)
            DIV_CAM: begin
                dvd = DIV_NW'({col_reg, 15'b0});
                dvs = (screen_width == 12'd0) ? DIV_VW'(1) : DIV_VW'(screen_width);
            end
            DIV_DX: begin
                dvd = DIV_NW'(64'h4000_0000);
                dvs = rx_abs;
            end
            DIV_DY: begin
                dvd = DIV_NW'(64'h4000_0000);
                dvs = ry_abs;
            end
            DIV_PERP: begin
                dvd = DIV_NW'({num_abs, 14'b0});
                dvs = side_reg ? ry_abs : rx_abs;
            end
            DIV_LH: begin
                dvd = DIV_NW'({screen_height, 10'b0});
                dvs = DIV_VW'(perp_reg);
            end
            DIV_TSTEP: begin
                dvd = DIV_NW'(TEX_SIZE * 65536);
                dvs = DIV_VW'(lh_reg);
            end
            default: begin
                dvd = '0;
                dvs = '0;
            end
        endcase
    end

    assign prodx_sh = prodx_reg >>> 14;
    assign prody_sh = prody_reg >>> 14;
    assign fx       = rx_reg[31] ? {1'b0, player_x[9:0]} : 11'd1024 - {1'b0, player_x[9:0]};
    assign fy       = ry_reg[31] ? {1'b0, player_y[9:0]} : 11'd1024 - {1'b0, player_y[9:0]};
    assign sdx_prod = 43'(fx) * 43'(dx_reg);
    assign sdy_prod = 43'(fy) * 43'(dy_reg);

    assign h2     = screen_height[11:1];
    assign lh2    = lh_reg[15:1];
    assign de_sum = 16'(lh2) + 16'(h2);
    always_comb begin
        if (screen_height == 12'd0) begin
            de_val = '0;
        end else if (de_sum >= 16'(screen_height)) begin
            de_val = 16'(screen_height) - 16'd1;
        end else begin
            de_val = de_sum;
        end
    end

    assign tprod = 38'(factor_reg) * 38'(tstep_reg);
    assign wlow  = (side_reg ? player_x[9:0] : player_y[9:0]) + wprod_reg[23:14];
    assign tmul  = 19'(wlow) * 19'(TEX_SIZE);

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ACCEPT: begin
                col_reg <= s_column;
            end
            OP_CAM: begin
                cam_reg <= $signed({1'b0, quo[26:0]}) - 28'sd16384;
            end
            OP_RAY_MUL: begin
                prodx_reg <= plane_x * cam_reg;
                prody_reg <= plane_y * cam_reg;
            end
            OP_RAY_ADD: begin
                rx_reg <= 32'(dir_x) + 32'(prodx_sh);
                ry_reg <= 32'(dir_y) + 32'(prody_sh);
                mx_reg <= MW'(player_x[15:10]);
                my_reg <= MW'(player_y[15:10]);
            end
            OP_DX: begin
                dx_reg <= quo[31:0];
            end
            OP_DY: begin
                dy_reg <= quo[31:0];
            end
            OP_SIDE: begin
                sdx_reg <= 48'(sdx_prod[42:10]);
                sdy_reg <= 48'(sdy_prod[42:10]);
            end
            OP_STEP: begin
                if (take_x) begin
                    sdx_reg <= sdx_reg + 48'(dx_reg);
                end else begin
                    sdy_reg <= sdy_reg + 48'(dy_reg);
                end
                mx_reg   <= mx_next;
                my_reg   <= my_next;
                side_reg <= !take_x;
            end
            OP_PERP: begin
                perp_reg <= (|quo[DIV_NW-1:18]) ? '1 : quo[17:0];
            end
            OP_LH: begin
                lh_reg <= (|quo[DIV_NW-1:16]) ? '1 : quo[15:0];
            end
            OP_DRAW: begin
                ds_reg     <= $signed({6'b0, h2}) - $signed({2'b0, lh2});
                de_reg     <= (de_val > 16'd2047) ? 11'd2047 : de_val[10:0];
                factor_reg <= (16'(lh2) > 16'(h2)) ? 16'(lh2) - 16'(h2) : 16'd0;
                wprod_reg  <= $signed({1'b0, perp_reg}) * (side_reg ? rx_reg : ry_reg);
            end
            OP_TSTEP: begin
                tstep_reg <= (|quo[DIV_NW-1:22]) ? '1 : quo[21:0];
            end
            OP_FINAL: begin
                tstart_reg <= (|tprod[37:32]) ? '1 : tprod[31:0];
                tcol_reg   <= tmul[15:10];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_cnt_reg <= '0;
        end else if (cmd.op == OP_SIDE) begin
            step_cnt_reg <= '0;
        end else if (cmd.op == OP_STEP) begin
            step_cnt_reg <= step_cnt_reg + SCW'(1);
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign load_out = cmd.op == OP_OUT_HIT || cmd.op == OP_OUT_MISS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_OUT_HIT) begin
            column_out_reg <= col_reg;
            hit_reg        <= 1'b1;
            face_reg       <= side_reg ? {1'b0, (!ry_reg[31] && (|ry_reg))} : {1'b1, rx_reg[31]};
            hcx_reg        <= 6'(mx_reg);
            hcy_reg        <= 6'(my_reg);
            perp_out_reg   <= perp_reg;
            lh_out_reg     <= lh_reg;
            ds_out_reg     <= ds_reg[16] ? 11'd0 : ds_reg[10:0];
            de_out_reg     <= de_reg;
            tcol_out_reg   <= tcol_reg;
            tstep_out_reg  <= tstep_reg;
            tstart_out_reg <= tstart_reg;
        end else if (cmd.op == OP_OUT_MISS) begin
            column_out_reg <= col_reg;
            hit_reg        <= 1'b0;
            face_reg       <= '0;
            hcx_reg        <= '0;
            hcy_reg        <= '0;
            perp_out_reg   <= '0;
            lh_out_reg     <= '0;
            ds_out_reg     <= '0;
            de_out_reg     <= '0;
            tcol_out_reg   <= '0;
            tstep_out_reg  <= '0;
            tstart_out_reg <= '0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_column_out     = column_out_reg;
    assign m_hit            = hit_reg;
    assign m_wall_face      = face_reg;
    assign m_hit_cell_x     = hcx_reg;
    assign m_hit_cell_y     = hcy_reg;
    assign m_perp_distance  = perp_out_reg;
    assign m_wall_height    = lh_out_reg;
    assign m_first_row      = ds_out_reg;
    assign m_last_row       = de_out_reg;
    assign m_texture_column = tcol_out_reg;
    assign m_tex_stride     = tstep_out_reg;
    assign m_texture_start  = tstart_out_reg;

    assign status.clear_busy = clear_busy_reg;
    assign status.div_busy   = div_busy;
    assign status.div_done   = div_done;
    assign status.player_in  = (32'(player_x[15:10]) < 32'(MAP_DIM)) &&
                               (32'(player_y[15:10]) < 32'(MAP_DIM));
    assign status.off_map    = (mx_reg < 0) || (mx_reg >= MAP_DIM) ||
                               (my_reg < 0) || (my_reg >= MAP_DIM);
    assign status.wall       = rd_data_reg;
    assign status.step_limit = step_cnt_reg == SCW'(MAX_STEPS);
    assign status.out_free   = out_free;

    `GRC_ASSERT_IMP(a_no_accept_in_clear, clear_busy_reg, cmd.op != OP_ACCEPT)
    `GRC_ASSERT_IMP(a_step_bound, cmd.op == OP_STEP, step_cnt_reg < SCW'(MAX_STEPS))
    `GRC_ASSERT_NXT(a_out_valid, load_out, m_valid_reg)

endmodule

@@ rtl/core/grid_ray_cast_column.sv @@
// Grid raycaster for one screen column. A write beat (opcode 0) stores one wall bit
// in the MAP_DIM x MAP_DIM map and yields no result. A cast beat (opcode 1) yields
// one result beat. A cast runs through one shared divider, used for camera x, both
// deltas, distance, line height and texture step (six divisions on a hit), with
// accept, multiply, setup and output steps around them, and one map read per DDA
// step. A ray whose player lies outside the map returns a miss after the camera x
// division. After reset the map is cleared one cell per cycle, all MAP_DIM*MAP_DIM
// cells, during which s_ready stays low; APB writes are taken at any time. A new
// beat is taken while a finished result waits on m_ready.
module grid_ray_cast_column
    import grc_pkg::*;
#(
    parameter int MAP_DIM   = MAP_DIM_DEF,
    parameter int TEX_SIZE  = TEX_SIZE_DEF,
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [5:0]  s_cell_x,
    input  logic [5:0]  s_cell_y,
    input  logic        s_cell_wall,
    input  logic [10:0] s_column,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_column_out,
    output logic        m_hit,
    output logic [1:0]  m_wall_face,
    output logic [5:0]  m_hit_cell_x,
    output logic [5:0]  m_hit_cell_y,
    output logic [17:0] m_perp_distance,
    output logic [15:0] m_wall_height,
    output logic [10:0] m_first_row,
    output logic [10:0] m_last_row,
    output logic [5:0]  m_texture_column,
    output logic [21:0] m_tex_stride,
    output logic [31:0] m_texture_start
);

    logic        [15:0] player_x_reg;
    logic        [15:0] player_y_reg;
    logic signed [15:0] dir_x_reg;
    logic signed [15:0] dir_y_reg;
    logic signed [15:0] plane_x_reg;
    logic signed [15:0] plane_y_reg;
    logic        [11:0] screen_w_reg;
    logic        [11:0] screen_h_reg;
    reg_idx_t           reg_idx;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            player_x_reg <= 16'd0;
            player_y_reg <= 16'd0;
            dir_x_reg    <= 16'sd16384;
            dir_y_reg    <= 16'sd0;
            plane_x_reg  <= 16'sd0;
            plane_y_reg  <= 16'sd10813;
            screen_w_reg <= 12'd640;
            screen_h_reg <= 12'd480;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_PLAYER_X: player_x_reg <= pwdata[15:0];
                REG_PLAYER_Y: player_y_reg <= pwdata[15:0];
                REG_DIR_X:    dir_x_reg    <= $signed(pwdata[15:0]);
                REG_DIR_Y:    dir_y_reg    <= $signed(pwdata[15:0]);
                REG_PLANE_X:  plane_x_reg  <= $signed(pwdata[15:0]);
                REG_PLANE_Y:  plane_y_reg  <= $signed(pwdata[15:0]);
                REG_SCREEN_W: screen_w_reg <= pwdata[11:0];
                REG_SCREEN_H: screen_h_reg <= pwdata[11:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PLAYER_X: prdata = 32'(player_x_reg);
            REG_PLAYER_Y: prdata = 32'(player_y_reg);
            REG_DIR_X:    prdata = 32'($unsigned(dir_x_reg));
            REG_DIR_Y:    prdata = 32'($unsigned(dir_y_reg));
            REG_PLANE_X:  prdata = 32'($unsigned(plane_x_reg));
            REG_PLANE_Y:  prdata = 32'($unsigned(plane_y_reg));
            REG_SCREEN_W: prdata = 32'(screen_w_reg);
            REG_SCREEN_H: prdata = 32'(screen_h_reg);
            default:      prdata = '0;
        endcase
    end

    grc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    grc_datapath #(
        .MAP_DIM   (MAP_DIM),
        .TEX_SIZE  (TEX_SIZE),
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .player_x         (player_x_reg),
        .player_y         (player_y_reg),
        .dir_x            (dir_x_reg),
        .dir_y            (dir_y_reg),
        .plane_x          (plane_x_reg),
        .plane_y          (plane_y_reg),
        .screen_width     (screen_w_reg),
        .screen_height    (screen_h_reg),
        .s_opcode         (s_opcode),
        .s_cell_x         (s_cell_x),
        .s_cell_y         (s_cell_y),
        .s_cell_wall      (s_cell_wall),
        .s_column         (s_column),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_column_out     (m_column_out),
        .m_hit            (m_hit),
        .m_wall_face      (m_wall_face),
        .m_hit_cell_x     (m_hit_cell_x),
        .m_hit_cell_y     (m_hit_cell_y),
        .m_perp_distance  (m_perp_distance),
        .m_wall_height    (m_wall_height),
        .m_first_row      (m_first_row),
        .m_last_row       (m_last_row),
        .m_texture_column (m_texture_column),
        .m_tex_stride     (m_tex_stride),
        .m_texture_start  (m_texture_start)
    );

endmodule

@@ verif/grid_ray_cast_column_checker.sv @@
module grid_ray_cast_column_checker
    import grc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_opcode,
    input  logic [5:0]  s_cell_x,
    input  logic [5:0]  s_cell_y,
    input  logic        s_cell_wall,
    input  logic [10:0] s_column,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [10:0] m_column_out,
    input  logic        m_hit,
    input  logic [1:0]  m_wall_face,
    input  logic [5:0]  m_hit_cell_x,
    input  logic [5:0]  m_hit_cell_y,
    input  logic [17:0] m_perp_distance,
    input  logic [15:0] m_wall_height,
    input  logic [10:0] m_first_row,
    input  logic [10:0] m_last_row,
    input  logic [5:0]  m_texture_column,
    input  logic [21:0] m_tex_stride,
    input  logic [31:0] m_texture_start,
    output int          mismatches,
    output int          pending
);

    localparam int MAP   = MAP_DIM_DEF;
    localparam int TEX   = TEX_SIZE_DEF;
    localparam int STEPS = MAX_STEPS_DEF;

    typedef struct {
        logic [10:0] column;
        logic        hit;
        logic [1:0]  face;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic [17:0] perp;
        logic [15:0] height;
        logic [10:0] top_row;
        logic [10:0] bottom_row;
        logic [5:0]  tex_col;
        logic [21:0] tex_step;
        logic [31:0] tex_start;
    } column_hit_t;

    bit                 wall_map [0:MAP*MAP-1];
    logic [15:0]        pos_x, pos_y;
    logic signed [15:0] view_x, view_y, cam_plane_x, cam_plane_y;
    logic [11:0]        scr_w, scr_h;
    column_hit_t        expected_columns [$];

    assign pending = expected_columns.size();

    function automatic longint floor_shr(longint v, int k);
        if (v >= 0) return v >>> k;
        return -((-v + (longint'(1) << k) - 1) >>> k);
    endfunction

    function automatic longint abs_of(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint delta_for(longint ray);
        if (ray == 0) return longint'(32'hFFFF_FFFF);
        return (longint'(1) << 30) / abs_of(ray);
    endfunction

    function automatic column_hit_t cast_column(logic [10:0] col);
        column_hit_t r;
        longint w, h, cam, rx, ry, mx, my, stx, sty, dx, dy, sdx, sdy;
        longint num, perp, lh, ds, de, wpos, tstep, tstart, px, py;
        int side;
        bit found;
        r = '{default: '0};
        r.column = col;
        side = 0;
        found = 0;
        px = longint'(pos_x);
        py = longint'(pos_y);
        w = scr_w == 0 ? 1 : longint'(scr_w);
        h = longint'(scr_h);
        cam = (longint'(col) * 32768) / w - 16384;
        rx = longint'(view_x) + floor_shr(longint'(cam_plane_x) * cam, 14);
        ry = longint'(view_y) + floor_shr(longint'(cam_plane_y) * cam, 14);
        mx = px >>> 10;
        my = py >>> 10;
        if (mx >= MAP || my >= MAP) return r;
        dx = delta_for(rx);
        dy = delta_for(ry);
        if (rx < 0) begin
            stx = -1; sdx = ((px & 1023) * dx) >>> 10;
        end else begin
            stx = 1; sdx = ((1024 - (px & 1023)) * dx) >>> 10;
        end
        if (ry < 0) begin
            sty = -1; sdy = ((py & 1023) * dy) >>> 10;
        end else begin
            sty = 1; sdy = ((1024 - (py & 1023)) * dy) >>> 10;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (sdx < sdy) begin
                sdx += dx; mx += stx; side = 0;
            end else begin
                sdy += dy; my += sty; side = 1;
            end
            if (mx < 0 || mx >= MAP || my < 0 || my >= MAP) return r;
            if (wall_map[my * MAP + mx]) begin
                found = 1;
                break;
            end
        end
        if (!found) return r;
        if (side == 0) begin
            num = mx * 1024 - px + (stx < 0 ? 1024 : 0);
            perp = rx == 0 ? 262143 : (abs_of(num) << 14) / abs_of(rx);
            r.face = rx < 0 ? 2'd3 : 2'd2;
        end else begin
            num = my * 1024 - py + (sty < 0 ? 1024 : 0);
            perp = ry == 0 ? 262143 : (abs_of(num) << 14) / abs_of(ry);
            r.face = ry > 0 ? 2'd1 : 2'd0;
        end
        if (perp > 262143) perp = 262143;
        if (perp == 0) lh = 65535;
        else begin
            lh = (h << 10) / perp;
            if (lh > 65535) lh = 65535;
        end
        ds = h / 2 - lh / 2;
        if (ds < 0) ds = 0;
        de = lh / 2 + h / 2;
        if (de >= h) de = h - 1;
        if (de < 0) de = 0;
        if (side == 0) wpos = py + floor_shr(perp * ry, 14);
        else wpos = px + floor_shr(perp * rx, 14);
        if (lh == 0) tstep = 4194303;
        else begin
            tstep = (longint'(TEX) << 16) / lh;
            if (tstep > 4194303) tstep = 4194303;
        end
        tstart = (ds - h / 2 + lh / 2) * tstep;
        if (tstart < 0) tstart = 0;
        if (tstart > longint'(32'hFFFF_FFFF)) tstart = longint'(32'hFFFF_FFFF);
        r.hit        = 1'b1;
        r.cell_x     = mx[5:0];
        r.cell_y     = my[5:0];
        r.perp       = perp[17:0];
        r.height     = lh[15:0];
        r.top_row    = ds > 2047 ? 11'd2047 : ds[10:0];
        r.bottom_row = de > 2047 ? 11'd2047 : de[10:0];
        r.tex_col    = 6'(((wpos & 1023) * TEX) >>> 10);
        r.tex_step   = tstep[21:0];
        r.tex_start  = tstart[31:0];
        return r;
    endfunction

    task automatic check_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        column_hit_t e;
        if (!aresetn) begin
            foreach (wall_map[i]) wall_map[i] = 0;
            pos_x = 0;
            pos_y = 0;
            view_x = 16384;
            view_y = 0;
            cam_plane_x = 0;
            cam_plane_y = 10813;
            scr_w = 640;
            scr_h = 480;
            expected_columns.delete();
            mismatches = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_PLAYER_X: pos_x = pwdata[15:0];
                    REG_PLAYER_Y: pos_y = pwdata[15:0];
                    REG_DIR_X:    view_x = pwdata[15:0];
                    REG_DIR_Y:    view_y = pwdata[15:0];
                    REG_PLANE_X:  cam_plane_x = pwdata[15:0];
                    REG_PLANE_Y:  cam_plane_y = pwdata[15:0];
                    REG_SCREEN_W: scr_w = pwdata[11:0];
                    REG_SCREEN_H: scr_h = pwdata[11:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (opcode_t'(s_opcode) == OPC_WRITE)
                    wall_map[int'(s_cell_y) * MAP + int'(s_cell_x)] = s_cell_wall;
                else
                    expected_columns.push_back(cast_column(s_column));
            end
            if (m_valid && m_ready) begin
                if (expected_columns.size() == 0) begin
                    $error("result beat with nothing expected, column %0d", m_column_out);
                    mismatches++;
                end else begin
                    e = expected_columns.pop_front();
                    check_field("column_out", e.column, m_column_out);
                    check_field("hit", e.hit, m_hit);
                    check_field("wall_face", e.face, m_wall_face);
                    check_field("hit_cell_x", e.cell_x, m_hit_cell_x);
                    check_field("hit_cell_y", e.cell_y, m_hit_cell_y);
                    check_field("perp_distance", e.perp, m_perp_distance);
                    check_field("wall_height", e.height, m_wall_height);
                    check_field("first_row", e.top_row, m_first_row);
                    check_field("last_row", e.bottom_row, m_last_row);
                    check_field("texture_column", e.tex_col, m_texture_column);
                    check_field("tex_stride", e.tex_step, m_tex_stride);
                    check_field("texture_start", e.tex_start, m_texture_start);
                end
            end
        end
    end

endmodule

@@ verif/testbench.sv @@
module testbench;
    import grc_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        s_valid, s_ready, s_opcode, s_cell_wall;
    logic [5:0]  s_cell_x, s_cell_y;
    logic [10:0] s_column;
    logic        m_valid, m_ready, m_hit;
    logic [10:0] m_column_out, m_first_row, m_last_row;
    logic [1:0]  m_wall_face;
    logic [5:0]  m_hit_cell_x, m_hit_cell_y, m_texture_column;
    logic [17:0] m_perp_distance;
    logic [15:0] m_wall_height;
    logic [21:0] m_tex_stride;
    logic [31:0] m_texture_start;
    int          mismatches, pending;
    int          send_idle_pct, recv_idle_pct;
    int          cur_width;

    grid_ray_cast_column u_top (.*);
    grid_ray_cast_column_checker u_chk (.*);

    always begin
        aclk = 1'b1; #1;
        aclk = 1'b0; #1;
    end

    always @(posedge aclk)
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);

    task automatic send_beat(opcode_t op, logic [5:0] cx, logic [5:0] cy, logic wall,
                             logic [10:0] col);
        bit taken;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_cell_x    <= cx;
        s_cell_y    <= cy;
        s_cell_wall <= wall;
        s_column    <= col;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_camera(logic [15:0] px, logic [15:0] py, logic [15:0] vx,
                                  logic [15:0] vy, logic [15:0] qx, logic [15:0] qy,
                                  logic [11:0] w, logic [11:0] h);
        s_valid <= 1'b0;
        @(negedge aclk);
        wait (pending == 0);
        repeat (600) @(posedge aclk);
        write_reg(REG_PLAYER_X, px);
        write_reg(REG_PLAYER_Y, py);
        write_reg(REG_DIR_X, vx);
        write_reg(REG_DIR_Y, vy);
        write_reg(REG_PLANE_X, qx);
        write_reg(REG_PLANE_Y, qy);
        write_reg(REG_SCREEN_W, w);
        write_reg(REG_SCREEN_H, h);
        cur_width = w == 0 ? 2048 : int'(w);
    endtask

    task automatic random_beat();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            if ($urandom_range(9) < 8)
                send_beat(OPC_CAST, 6'($urandom), 6'($urandom), 1'($urandom),
                          11'($urandom_range(0, cur_width - 1)));
            else
                send_beat(OPC_CAST, 6'($urandom), 6'($urandom), 1'($urandom),
                          11'($urandom));
        end else if (r < 94) begin
            send_beat(OPC_WRITE, 6'($urandom_range(1, 62)), 6'($urandom_range(1, 62)),
                      $urandom_range(99) < 35, 11'($urandom));
        end else begin
            send_beat(OPC_WRITE, 6'($urandom), 6'($urandom), 1'($urandom), 11'($urandom));
        end
    endtask

    function automatic logic [15:0] inner_pos();
        return {6'($urandom_range(1, 62)), 10'($urandom)};
    endfunction

    initial begin
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_opcode = 1'b0; s_cell_x = '0; s_cell_y = '0;
        s_cell_wall = 1'b0; s_column = '0; m_ready = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 69;
        cur_width = 640;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty map at first, reset camera: rays leave the map or hit walls written here
        send_beat(OPC_CAST, 6'd0, 6'd0, 1'b0, 11'd0);
        send_beat(OPC_CAST, 6'd63, 6'd63, 1'b1, 11'd2047);
        send_beat(OPC_WRITE, 6'd3, 6'd0, 1'b1, 11'd0);
        send_beat(OPC_CAST, 6'd0, 6'd0, 1'b0, 11'd320);
        send_beat(OPC_CAST, 6'd0, 6'd0, 1'b0, 11'd639);
        send_beat(OPC_WRITE, 6'd0, 6'd2, 1'b1, 11'd2047);
        send_beat(OPC_CAST, 6'd0, 6'd0, 1'b0, 11'd1365);
        send_beat(OPC_CAST, 6'd0, 6'd0, 1'b0, 11'd682);
        send_beat(OPC_WRITE, 6'd63, 6'd63, 1'b1, 11'd0);
        send_beat(OPC_WRITE, 6'd42, 6'd21, 1'b1, 11'd0);
        send_beat(OPC_WRITE, 6'd21, 6'd42, 1'b0, 11'd0);
        send_beat(OPC_WRITE, 6'd3, 6'd0, 1'b0, 11'd0);
        send_beat(OPC_CAST, 6'd0, 6'd0, 1'b0, 11'd320);
        send_beat(OPC_WRITE, 6'd1, 6'd0, 1'b1, 11'd0);
        send_beat(OPC_CAST, 6'd0, 6'd0, 1'b0, 11'd640);
        send_beat(OPC_CAST, 6'd0, 6'd0, 1'b0, 11'd1000);

        // closed border, so rays cast from inner cells stay inside while it holds
        for (int i = 0; i < 64; i++) begin
            send_beat(OPC_WRITE, 6'(i), 6'd0, 1'b1, 11'd0);
            send_beat(OPC_WRITE, 6'(i), 6'd63, 1'b1, 11'd0);
            send_beat(OPC_WRITE, 6'd0, 6'(i), 1'b1, 11'd0);
            send_beat(OPC_WRITE, 6'd63, 6'(i), 1'b1, 11'd0);
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: program_camera(inner_pos(), inner_pos(), 16'd16384, 16'd0, 16'd0,
                                  16'd10813, 12'd640, 12'd480);
                1: program_camera(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF,
                                  16'h8000, 12'd1, 12'hFFF);
                2: program_camera(inner_pos(), inner_pos(), 16'd0, 16'd16384, 16'd0,
                                  16'd0, 12'd0, 12'd0);
                default: program_camera(inner_pos(), inner_pos(), 16'($urandom),
                                        16'($urandom), 16'($urandom), 16'($urandom),
                                        12'($urandom_range(1, 2048)),
                                        12'($urandom_range(1, 2048)));
            endcase
            for (int n = 0; n < 285; n++) begin
                if (ph == 2 && n == 0) begin
                    send_idle_pct = 69;
                    recv_idle_pct = 10;
                end
                if (ph == 4 && n == 0) begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                random_beat();
            end
        end
        s_valid <= 1'b0;

        @(negedge aclk);
        wait (pending == 0);
        repeat (600) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #40000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/grc_pkg.sv
rtl/core/grc_div.sv
rtl/core/grc_ctrl.sv
rtl/core/grc_datapath.sv
rtl/core/grid_ray_cast_column.sv
verif/grid_ray_cast_column_checker.sv
verif/testbench.sv
